@@ rtl/mvt_pkg.sv @@
// shared constants, types and register map for the 4x4 matrix by vector transform
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int CSR_W         = 64;
   localparam int CSR_IDX_W     = 4;
   localparam int NUM_REGS      = 8;
   localparam int NUM_ROWS      = 4;
   localparam int NUM_COLS      = 4;
   localparam int FRAC_BITS_DEF = 16;

   // register map, two coefficients per register
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

   // identity matrix in Q16.16
   localparam logic [CSR_W-1:0] CSR_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
   };

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // control that travels down the pipeline beside the data
   typedef struct packed {
      logic valid;
      logic point;
   } pipe_ctl_type;

endpackage : mvt_pkg

`default_nettype wire

@@ rtl/mvt_csr.sv @@
// coefficient register bank: eight 64-bit registers, split into sixteen coefficients
// depends on mvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvt_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [mvt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mvt_pkg::CSR_W-1:0]           csr_wdata,
   output logic signed [mvt_pkg::DATA_W-1:0]        coef [mvt_pkg::NUM_ROWS][mvt_pkg::NUM_COLS]
);
   import mvt_pkg::*;

   logic [CSR_W-1:0] regs_ff [NUM_REGS];
   logic [CSR_W-1:0] regs_in [NUM_REGS];

   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ROW0_COLS01: regs_in[0] = csr_wdata;
            REG_ROW0_COLS23: regs_in[1] = csr_wdata;
            REG_ROW1_COLS01: regs_in[2] = csr_wdata;
            REG_ROW1_COLS23: regs_in[3] = csr_wdata;
            REG_ROW2_COLS01: regs_in[4] = csr_wdata;
            REG_ROW2_COLS23: regs_in[5] = csr_wdata;
            REG_ROW3_COLS01: regs_in[6] = csr_wdata;
            REG_ROW3_COLS23: regs_in[7] = csr_wdata;
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= CSR_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // low half holds the even column
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         coef[r][0] = regs_ff[2*r][DATA_W-1:0];
         coef[r][1] = regs_ff[2*r][2*DATA_W-1:DATA_W];
         coef[r][2] = regs_ff[2*r+1][DATA_W-1:0];
         coef[r][3] = regs_ff[2*r+1][2*DATA_W-1:DATA_W];
      end
   end

endmodule : mvt_csr

`default_nettype wire

@@ rtl/mvt_mul_array.sv @@
// first pipeline stage: sixteen exact signed 32x32 products, registered
// depends on mvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvt_mul_array (
   input  wire logic                                clock,
   input  wire logic signed [mvt_pkg::DATA_W-1:0]   vec  [mvt_pkg::NUM_COLS],
   input  wire logic signed [mvt_pkg::DATA_W-1:0]   coef [mvt_pkg::NUM_ROWS][mvt_pkg::NUM_COLS],
   output logic signed [mvt_pkg::PROD_W-1:0]        prod_ff [mvt_pkg::NUM_ROWS][mvt_pkg::NUM_COLS]
);
   import mvt_pkg::*;

   logic signed [PROD_W-1:0] prod_in [NUM_ROWS][NUM_COLS];

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            prod_in[r][c] = coef[r][c] * vec[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule : mvt_mul_array

`default_nettype wire

@@ rtl/mvt_row_sum.sv @@
// one row of the product: scale, two-level adder tree and saturation over two stages
// depends on mvt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvt_row_sum #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic signed [mvt_pkg::PROD_W-1:0]   prod [mvt_pkg::NUM_COLS],
   input  wire logic                                kill,
   output logic signed [mvt_pkg::DATA_W-1:0]        value_ff,
   output logic                                     sat_ff
);
   import mvt_pkg::*;

   localparam int SHIFT_W = PROD_W - FRAC_BITS;
   localparam int PAIR_W  = SHIFT_W + 1;
   localparam int SUM_W   = SHIFT_W + 2;

   logic signed [SHIFT_W-1:0] scaled [NUM_COLS];
   logic signed [PAIR_W-1:0]  pair_in [2];
   logic signed [PAIR_W-1:0]  pair_ff [2];
   logic signed [SUM_W-1:0]   total;
   logic [SUM_W-DATA_W:0]     total_top;
   logic                      ovf;
   logic signed [DATA_W-1:0]  value_in;
   logic                      sat_in;

   // dropping the low bits is a floor shift
   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         scaled[c] = prod[c][PROD_W-1:FRAC_BITS];
      end
      for (int p = 0; p < 2; p++) begin
         pair_in[p] = {scaled[2*p][SHIFT_W-1], scaled[2*p]}
                    + {scaled[2*p+1][SHIFT_W-1], scaled[2*p+1]};
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   always_comb begin
      total     = {pair_ff[0][PAIR_W-1], pair_ff[0]} + {pair_ff[1][PAIR_W-1], pair_ff[1]};
      total_top = total[SUM_W-1:DATA_W-1];
      ovf       = !((&total_top) || !(|total_top));
      if (kill) begin
         value_in = '0;
         sat_in   = 1'b0;
      end else if (ovf) begin
         value_in = total[SUM_W-1] ? SAT_MIN : SAT_MAX;
         sat_in   = 1'b1;
      end else begin
         value_in = total[DATA_W-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

endmodule : mvt_row_sum

`default_nettype wire

@@ rtl/matrix_vector_transform_4x4.sv @@
// top level of the 4x4 matrix by vector transform: register bank, multiplier stage, row sums
// depends on mvt_pkg, mvt_csr, mvt_mul_array, mvt_row_sum
`timescale 1ns / 1ps
`default_nettype none

// multiplies a 4x4 matrix of signed fixed point coefficients (Q16.16 at the default
// FRAC_BITS) by one 4-element vector per item. an item is taken on every clock edge
// where start is high; busy is never raised, so a new item may follow in every cycle.
// each result appears on the rsp_ ports for one cycle with rsp_valid high, once its item
// has passed the multiplier stage, the pair adders and the final add and clip,
// and the sustained rate is one item per cycle. results cannot be held off, so the
// receiver must take each one in the cycle it is shown. every product is formed exactly,
// floor-shifted right by FRAC_BITS, summed, and clipped to 32 bits; rsp_saturated is set
// when any reported component was clipped. with req_action high the w input is taken as
// 1.0 and rsp_out_w reads zero, which then never raises the flag. coefficients are
// written two to a 64-bit register through the csr_ port, by the user only while no item
// is in flight (not enforced by the block); identity at reset, unmapped indexes ignored.
module matrix_vector_transform_4x4 #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item in
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_action,
   input  wire logic signed [mvt_pkg::DATA_W-1:0]   req_vec_x,
   input  wire logic signed [mvt_pkg::DATA_W-1:0]   req_vec_y,
   input  wire logic signed [mvt_pkg::DATA_W-1:0]   req_vec_z,
   input  wire logic signed [mvt_pkg::DATA_W-1:0]   req_vec_w,
   // item out
   output logic                                     rsp_valid,
   output logic signed [mvt_pkg::DATA_W-1:0]        rsp_out_x,
   output logic signed [mvt_pkg::DATA_W-1:0]        rsp_out_y,
   output logic signed [mvt_pkg::DATA_W-1:0]        rsp_out_z,
   output logic signed [mvt_pkg::DATA_W-1:0]        rsp_out_w,
   output logic                                     rsp_saturated,
   // coefficient writes
   input  wire logic                                csr_we,
   input  wire logic [mvt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mvt_pkg::CSR_W-1:0]           csr_wdata
);
   import mvt_pkg::*;

   // 1.0 in the chosen fixed point format
   localparam logic signed [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;

   logic                      accept;
   logic signed [DATA_W-1:0]  vec  [NUM_COLS];
   logic signed [DATA_W-1:0]  coef [NUM_ROWS][NUM_COLS];
   logic signed [PROD_W-1:0]  prod [NUM_ROWS][NUM_COLS];
   logic signed [DATA_W-1:0]  row_value [NUM_ROWS];
   logic                      row_sat   [NUM_ROWS];

   // control pipeline: products, pair sums, clipped result
   pipe_ctl_type ctl_in;
   pipe_ctl_type ctl_s1_ff;
   pipe_ctl_type ctl_s2_ff;
   pipe_ctl_type ctl_s3_ff;

   // nothing ever backs up: the pipeline runs freely
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign ctl_in.valid = accept;
   assign ctl_in.point = req_action;

   // point transform replaces w by one
   always_comb begin
      vec[0] = req_vec_x;
      vec[1] = req_vec_y;
      vec[2] = req_vec_z;
      vec[3] = req_action ? ONE_FIX : req_vec_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s1_ff <= '0;
         ctl_s2_ff <= '0;
         ctl_s3_ff <= '0;
      end else begin
         ctl_s1_ff <= ctl_in;
         ctl_s2_ff <= ctl_s1_ff;
         ctl_s3_ff <= ctl_s2_ff;
      end
   end

   mvt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // stage one: all sixteen products at once
   mvt_mul_array u_mul (
      .clock   (clock),
      .vec     (vec),
      .coef    (coef),
      .prod_ff (prod)
   );

   // stages two and three, one adder tree per row
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
      logic kill;
      // row w is dropped in a point transform, flag included
      if (r == NUM_ROWS - 1) begin : g_w
         assign kill = ctl_s2_ff.point;
      end else begin : g_xyz
         assign kill = 1'b0;
      end

      mvt_row_sum #(
         .FRAC_BITS (FRAC_BITS)
      ) u_row (
         .clock    (clock),
         .prod     (prod[r]),
         .kill     (kill),
         .value_ff (row_value[r]),
         .sat_ff   (row_sat[r])
      );
   end

   assign rsp_valid     = ctl_s3_ff.valid;
   assign rsp_out_x     = row_value[0];
   assign rsp_out_y     = row_value[1];
   assign rsp_out_z     = row_value[2];
   assign rsp_out_w     = row_value[3];
   assign rsp_saturated = row_sat[0] || row_sat[1] || row_sat[2] || row_sat[3];

   // a result only ever comes from an item whose valid bit went through ctl_s1, ctl_s2 and ctl_s3
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3))
      else $error("result without a matching item");

   // a raised flag means some component sits at a rail
   a_sat_rail : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_out_x == SAT_MAX || rsp_out_x == SAT_MIN ||
          rsp_out_y == SAT_MAX || rsp_out_y == SAT_MIN ||
          rsp_out_z == SAT_MAX || rsp_out_z == SAT_MIN ||
          rsp_out_w == SAT_MAX || rsp_out_w == SAT_MIN))
      else $error("saturation flag with no clipped component");

   // point transform items come out with w cleared
   a_point_w : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action, 3)) |-> (rsp_out_w == '0))
      else $error("point transform gave non-zero w");

endmodule : matrix_vector_transform_4x4

`default_nettype wire

@@ dv/tb_matrix_vector_transform_4x4.sv @@
// self-checking testbench for the 4x4 matrix by vector transform, with predictor and scoreboard
// depends on mvt_pkg and matrix_vector_transform_4x4 from the rtl folder
`timescale 1ns / 1ps

module tb_matrix_vector_transform_4x4;
   import mvt_pkg::*;

   // block settings as the testbench sees them
   localparam int FRAC_BITS       = FRAC_BITS_DEF;
   localparam int LATENCY         = 3;       // cycles from item taken to result shown
   localparam int RESET_CYCLES    = 9;
   localparam int IDLE_PCT        = 37;      // chance in a hundred of a sender gap
   localparam int CYCLE_LIMIT     = 200000;  // cycle count at which the watchdog ends the run
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int QUIET_PHASE     = 2;       // phase sent without random sender gaps
   localparam int MAX_REPORTS     = 20;

   // action codes
   localparam logic ACT_FULL  = 1'b0;
   localparam logic ACT_POINT = 1'b1;

   // register indexes past the end of the map, writes to them must be dropped
   localparam logic [CSR_IDX_W-1:0] IDX_UNMAPPED_LO = CSR_IDX_W'(NUM_REGS);
   localparam logic [CSR_IDX_W-1:0] IDX_UNMAPPED_HI = '1;

   // 1.0 in the fixed point format, used for w in point transforms
   localparam logic signed [DATA_W-1:0] FIX_ONE = 32'sd1 <<< FRAC_BITS;

   // uniform register images for the extreme matrices
   localparam logic [CSR_W-1:0] ALL_MAX  = {SAT_MAX, SAT_MAX};
   localparam logic [CSR_W-1:0] ALL_MIN  = {SAT_MIN, SAT_MIN};
   localparam logic [CSR_W-1:0] ALL_ZERO = '0;

   typedef enum int {COEF_SMALL, COEF_FULL, COEF_EXTREME} coef_style_type;

   typedef struct packed {
      logic                     action;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] w;
   } vec_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] w;
      logic                     clipped;
   } xform_result_type;

   // holds the coefficient copy, predicts each item and checks results in order
   class xform_scoreboard;
      logic [CSR_W-1:0] coef_regs [NUM_REGS];
      xform_result_type expected_q [$];
      int unsigned      mismatches;
      int unsigned      items_seen;
      int unsigned      points_seen;
      int unsigned      results_seen;
      int unsigned      clipped_seen;

      function new();
         foreach (coef_regs[i]) coef_regs[i] = CSR_RESET[i];
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
      endtask

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx < NUM_REGS) coef_regs[idx] = data;
      endfunction

      // column 0 or 2 in the low half, column 1 or 3 in the high half
      function logic signed [DATA_W-1:0] coef(int row, int col);
         logic [CSR_W-1:0] r;
         r = coef_regs[2 * row + col / 2];
         return (col % 2) ? r[CSR_W-1:DATA_W] : r[DATA_W-1:0];
      endfunction

      function xform_result_type transform(vec_item_type it);
         logic signed [DATA_W-1:0] v [NUM_COLS];
         logic signed [DATA_W-1:0] o [NUM_ROWS];
         logic signed [DATA_W-1:0] c;
         logic signed [PROD_W-1:0] prod;
         logic signed [PROD_W-1:0] acc;
         xform_result_type         r;
         r.clipped = 1'b0;
         v[0] = it.x;
         v[1] = it.y;
         v[2] = it.z;
         v[3] = (it.action == ACT_POINT) ? FIX_ONE : it.w;
         for (int row = 0; row < NUM_ROWS; row++) begin
            acc = '0;
            for (int col = 0; col < NUM_COLS; col++) begin
               c    = coef(row, col);
               prod = c * v[col];               // exact, 64-bit signed context
               acc  = acc + (prod >>> FRAC_BITS); // floor shift
            end
            if (row == NUM_ROWS - 1 && it.action == ACT_POINT) begin
               o[row] = '0;                     // row 3 not evaluated, cannot clip
            end else if (acc > SAT_MAX) begin
               o[row]    = SAT_MAX;
               r.clipped = 1'b1;
            end else if (acc < SAT_MIN) begin
               o[row]    = SAT_MIN;
               r.clipped = 1'b1;
            end else begin
               o[row] = acc[DATA_W-1:0];
            end
         end
         r.x = o[0];
         r.y = o[1];
         r.z = o[2];
         r.w = o[3];
         return r;
      endfunction

      function void note_item(vec_item_type it);
         items_seen++;
         if (it.action == ACT_POINT) points_seen++;
         expected_q.push_back(transform(it));
      endfunction

      task compare_field(string name, logic signed [DATA_W-1:0] got,
                         logic signed [DATA_W-1:0] want);
         if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(xform_result_type got);
         xform_result_type want;
         if (expected_q.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         want = expected_q.pop_front();
         results_seen++;
         if (got.clipped === 1'b1) clipped_seen++;
         compare_field("out_x", got.x, want.x);
         compare_field("out_y", got.y, want.y);
         compare_field("out_z", got.z, want.z);
         compare_field("out_w", got.w, want.w);
         if (got.clipped !== want.clipped)
            report($sformatf("saturated got %b expected %b", got.clipped, want.clipped));
      endtask
   endclass

   // block ports, every input known from time zero
   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        start         = 1'b0;
   logic                        busy;
   logic                        req_action    = ACT_FULL;
   logic signed [DATA_W-1:0]    req_vec_x     = '0;
   logic signed [DATA_W-1:0]    req_vec_y     = '0;
   logic signed [DATA_W-1:0]    req_vec_z     = '0;
   logic signed [DATA_W-1:0]    req_vec_w     = '0;
   logic                        rsp_valid;
   logic signed [DATA_W-1:0]    rsp_out_x;
   logic signed [DATA_W-1:0]    rsp_out_y;
   logic signed [DATA_W-1:0]    rsp_out_z;
   logic signed [DATA_W-1:0]    rsp_out_w;
   logic                        rsp_saturated;
   logic                        csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index     = '0;
   logic [CSR_W-1:0]            csr_wdata     = '0;

   xform_scoreboard sb = new();
   int unsigned     cycles = 0;
   int unsigned     settings_used = 1;   // reset identity counts as the first

   matrix_vector_transform_4x4 #(
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .req_vec_w     (req_vec_w),
      .rsp_valid     (rsp_valid),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_w     (rsp_out_w),
      .rsp_saturated (rsp_saturated),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog, a hung handshake ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // sample everything on the rising edge; results are checked before the new item is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(xform_result_type'{x: rsp_out_x, y: rsp_out_y, z: rsp_out_z,
                                               w: rsp_out_w, clipped: rsp_saturated});
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy)
            sb.note_item(vec_item_type'{action: req_action, x: req_vec_x, y: req_vec_y,
                                        z: req_vec_z, w: req_vec_w});
      end
   end

   function automatic vec_item_type mk_item(logic act, logic signed [DATA_W-1:0] x,
                                            logic signed [DATA_W-1:0] y,
                                            logic signed [DATA_W-1:0] z,
                                            logic signed [DATA_W-1:0] w);
      return vec_item_type'{action: act, x: x, y: y, z: z, w: w};
   endfunction

   // vector components: mostly modest magnitudes, with extremes and raw bit patterns
   function automatic logic signed [DATA_W-1:0] rand_comp();
      case ($urandom_range(0, 9))
         0:       return SAT_MAX;
         1:       return SAT_MIN;
         2:       return '0;
         3, 4:    return $urandom;
         default: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;  // about +-16.0
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_coef(coef_style_type style);
      case (style)
         COEF_SMALL: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;  // about +-4.0
         COEF_FULL:  return $urandom;
         default: begin
            case ($urandom_range(0, 5))
               0:       return SAT_MAX;
               1:       return SAT_MIN;
               2:       return '0;
               3:       return FIX_ONE;
               4:       return -FIX_ONE;
               default: return $urandom;
            endcase
         end
      endcase
   endfunction

   function automatic vec_item_type rand_item();
      return mk_item(($urandom_range(0, 2) == 0) ? ACT_POINT : ACT_FULL,
                     rand_comp(), rand_comp(), rand_comp(), rand_comp());
   endfunction

   // present one item at the falling edge and hold it until taken
   task automatic send_item(vec_item_type it, bit may_idle);
      while (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         start <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      start      <= 1'b1;
      req_action <= it.action;
      req_vec_x  <= it.x;
      req_vec_y  <= it.y;
      req_vec_z  <= it.z;
      req_vec_w  <= it.w;
      do @(posedge clock); while (busy);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // write enable stays high across back-to-back writes
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic load_uniform(logic [CSR_W-1:0] val);
      wait_idle();
      for (int i = 0; i < NUM_REGS; i++) write_csr(CSR_IDX_W'(i), val);
      end_writes();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset identity: extremes pass straight through, point mode ignores w
      send_item(mk_item(ACT_FULL, FIX_ONE, 2 * FIX_ONE, -3 * FIX_ONE, FIX_ONE / 2), 1);
      send_item(mk_item(ACT_FULL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1);
      send_item(mk_item(ACT_FULL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1);
      send_item(mk_item(ACT_FULL, '0, '0, '0, '0), 1);
      send_item(mk_item(ACT_FULL, -1, -1, -1, -1), 0);
      send_item(mk_item(ACT_POINT, SAT_MAX, SAT_MIN, -1, SAT_MIN), 0);
      send_item(mk_item(ACT_POINT, $urandom, $urandom, $urandom, $urandom), 0);
      send_item(mk_item(ACT_FULL, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'h5555_5555), 1);

      // largest positive coefficients: clipping both ways, and an exact hit on the top
      // value in point mode where the huge row 3 must not raise the flag
      load_uniform(ALL_MAX);
      send_item(mk_item(ACT_FULL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1);
      send_item(mk_item(ACT_FULL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1);
      send_item(mk_item(ACT_POINT, '0, '0, '0, SAT_MAX), 1);
      send_item(mk_item(ACT_FULL, FIX_ONE, -FIX_ONE, '0, '0), 1);
      send_item(mk_item(ACT_FULL, -1, 1, -1, 1), 1);

      // most negative coefficients: min times min clips high
      load_uniform(ALL_MIN);
      send_item(mk_item(ACT_FULL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1);
      send_item(mk_item(ACT_FULL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1);
      send_item(mk_item(ACT_POINT, -1, -1, -1, SAT_MAX), 1);

      // writes past the register map must leave the matrix alone
      wait_idle();
      write_csr(IDX_UNMAPPED_LO, '1);
      write_csr(IDX_UNMAPPED_HI, {$urandom, $urandom});
      end_writes();
      send_item(rand_item(), 1);
      send_item(mk_item(ACT_FULL, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX), 1);

      // all-zero matrix
      load_uniform(ALL_ZERO);
      send_item(mk_item(ACT_FULL, SAT_MAX, SAT_MIN, $urandom, $urandom), 1);
      send_item(mk_item(ACT_POINT, SAT_MIN, SAT_MAX, $urandom, $urandom), 1);

      // random phases, each with a fresh matrix written while idle; pauses now and then
      // drain the pipe mid-phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         for (int i = 0; i < NUM_REGS; i++)
            write_csr(CSR_IDX_W'(i), {rand_coef(coef_style_type'(ph % 3)),
                                      rand_coef(coef_style_type'(ph % 3))});
         if ($urandom_range(0, 1))
            write_csr(IDX_UNMAPPED_LO + CSR_IDX_W'($urandom_range(0, 7)),
                      {$urandom, $urandom});
         end_writes();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 199) == 0) wait_idle();
            send_item(rand_item(), ph != QUIET_PHASE);
         end
      end

      wait_idle();
      $display("covered %0d items (%0d point transforms) over %0d coefficient settings",
               sb.items_seen, sb.points_seen, settings_used);
      $display("checked %0d results, %0d of them clipped", sb.results_seen, sb.clipped_seen);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mvt_pkg.sv
rtl/mvt_csr.sv
rtl/mvt_mul_array.sv
rtl/mvt_row_sum.sv
rtl/matrix_vector_transform_4x4.sv
dv/tb_matrix_vector_transform_4x4.sv
